// ===== hdl/lca_pkg.sv =====
// Shared types and constants for the Life cellular automaton engine.
// No dependencies; imported by the cell rule and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lca_pkg;

  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLUMNS = 64;

  localparam int ACT_W  = 2;
  localparam int ROW_IN_W = 6;
  localparam int COL_IN_W = 6;
  localparam int CFG_W  = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 7'd64;

  // B3/S23
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // 3x3 neighborhood around one cell, edges already forced dead
  typedef struct packed {
    logic [2:0] above;
    logic       left;
    logic       right;
    logic [2:0] below;
    logic       self;
  } nbhd_t;

endpackage

`default_nettype wire

// ===== hdl/lca_row_ram.sv =====
// Row-wide plane store: one row word per address, per-bit write enables,
// registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lca_row_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wbe,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wbe[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/lca_cell_rule.sv =====
// Shared next-state unit: counts the eight neighbors and applies B3/S23.
// Depends on lca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lca_cell_rule (
  input  lca_pkg::nbhd_t nb,
  output logic           next_alive
);
  import lca_pkg::*;

  logic [3:0] count;

  always_comb begin
    count = 4'(nb.above[0]) + 4'(nb.above[1]) + 4'(nb.above[2])
          + 4'(nb.left) + 4'(nb.right)
          + 4'(nb.below[0]) + 4'(nb.below[1]) + 4'(nb.below[2]);
    next_alive = (count == BIRTH_COUNT) || (nb.self && (count == SURVIVE_COUNT));
  end

endmodule

`default_nettype wire

// ===== hdl/life_cellular_automaton_engine_top.sv =====
// A write or out-of-range request is answered from the accepting state; an in-range read
//   waits in S_RD_WAIT for the plane read; an advance sweeps each row in use one cell per
//   cycle through the rule unit, then copies the unused rows, before S_DONE answers.
// Throughput: one request at a time; ready stays low until its result is registered.
// Reset: synchronous active low; a clearing pass zeroes both planes one row a cycle,
//   during which no request is taken.
`timescale 1ns / 1ps
`default_nettype none

module life_cellular_automaton_engine_top #(
  parameter int MAX_ROWS    = lca_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = lca_pkg::DEF_MAX_COLUMNS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lca_pkg::ACT_W-1:0]      in_action,
  input  wire logic [lca_pkg::ROW_IN_W-1:0]   in_row,
  input  wire logic [lca_pkg::COL_IN_W-1:0]   in_column,
  input  wire logic                           in_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_cell_state,
  output logic                                out_accepted,
  input  wire logic                           cfg_we,
  input  wire logic [lca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lca_pkg::CFG_W-1:0]      cfg_data
);
  import lca_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_RD_WAIT   = 4'd2;
  localparam logic [3:0] S_ADV_START = 4'd3;
  localparam logic [3:0] S_PRIME     = 4'd4;
  localparam logic [3:0] S_READ      = 4'd5;
  localparam logic [3:0] S_LOAD      = 4'd6;
  localparam logic [3:0] S_SWEEP     = 4'd7;
  localparam logic [3:0] S_WRITE     = 4'd8;
  localparam logic [3:0] S_COPY_RD   = 4'd9;
  localparam logic [3:0] S_COPY_WR   = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  logic [3:0]             state_r, state_nxt;
  logic [ROW_W-1:0]       r_r;
  logic [ROW_W:0]         r_inc;
  logic [COL_W-1:0]       col_r;
  logic [COL_W-1:0]       col_hold_r;
  logic                   active_r;
  logic [CFG_W-1:0]       row_count_r, column_count_r;
  logic                   out_valid_r, out_cell_state_r, out_accepted_r;

  // raw rows of the source plane around the row being swept
  logic [MAX_COLUMNS-1:0] prev_raw_r, cur_raw_r, nxt_raw_r;
  // masked window rows, shifted one column per sweep cycle
  logic [MAX_COLUMNS-1:0] wa_r, wm_r, wb_r, mk_r, dst_r;
  logic                   a_prev_r, m_prev_r, b_prev_r;

  logic [RCNT_W-1:0]      nr;
  logic [CCNT_W-1:0]      nc;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic                   in_accept, in_range;
  logic                   last_row_active, below_valid;

  logic [MAX_COLUMNS-1:0] rdata_a, rdata_b, rd_data;
  logic [ROW_W-1:0]       raddr, waddr;
  logic [MAX_COLUMNS-1:0] wbe, wdata;
  logic                   we_a, we_b, we_cur, we_dst, we_clr;

  nbhd_t                  nb;
  logic                   next_alive, ins_bit;

  always_comb begin
    if (32'(row_count_r) > 32'(MAX_ROWS)) begin
      nr = RCNT_W'(MAX_ROWS);
    end else begin
      nr = RCNT_W'(row_count_r);
    end
    if (32'(column_count_r) > 32'(MAX_COLUMNS)) begin
      nc = CCNT_W'(MAX_COLUMNS);
    end else begin
      nc = CCNT_W'(column_count_r);
    end
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      col_mask[i] = (i < int'(nc));
    end
  end

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_accept = in_valid && in_ready;
  assign in_range  = (32'(in_row) < 32'(nr)) && (32'(in_column) < 32'(nc));
  assign r_inc     = {1'b0, r_r} + 1'b1;
  assign last_row_active = (32'(r_inc) == 32'(nr));
  assign below_valid     = (32'(r_inc) < 32'(nr));
  assign rd_data   = active_r ? rdata_b : rdata_a;

  assign out_valid      = out_valid_r;
  assign out_cell_state = out_cell_state_r;
  assign out_accepted   = out_accepted_r;

  // neighborhood of column col_r; window bit 0 is the current column
  assign nb.above = {a_prev_r, wa_r[0], wa_r[1]};
  assign nb.left  = m_prev_r;
  assign nb.right = wm_r[1];
  assign nb.below = {b_prev_r, wb_r[0], wb_r[1]};
  assign nb.self  = wm_r[0];

  lca_cell_rule u_rule (
    .nb         (nb),
    .next_alive (next_alive)
  );

  // columns beyond the active grid keep their old value
  assign ins_bit = mk_r[0] ? next_alive : dst_r[0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (32'(r_r) == 32'(MAX_ROWS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_action == ACT_READ && in_range) begin
            state_nxt = S_RD_WAIT;
          end else if (in_action == ACT_ADVANCE) begin
            state_nxt = S_ADV_START;
          end
        end
      end
      S_RD_WAIT:   state_nxt = S_IDLE;
      S_ADV_START: state_nxt = (nr == '0) ? S_COPY_RD : S_PRIME;
      S_PRIME:     state_nxt = S_READ;
      S_READ:      state_nxt = S_LOAD;
      S_LOAD:      state_nxt = S_SWEEP;
      S_SWEEP: begin
        if (col_r == COL_W'(MAX_COLUMNS - 1)) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (last_row_active) begin
          state_nxt = (32'(r_inc) == 32'(MAX_ROWS)) ? S_DONE : S_COPY_RD;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_COPY_RD: state_nxt = S_COPY_WR;
      S_COPY_WR: begin
        state_nxt = (32'(r_r) == 32'(MAX_ROWS - 1)) ? S_DONE : S_COPY_RD;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // plane port control
  always_comb begin
    raddr  = r_r;
    waddr  = r_r;
    wbe    = '1;
    wdata  = dst_r;
    we_cur = 1'b0;
    we_dst = 1'b0;
    we_clr = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        we_clr = 1'b1;
        wdata  = '0;
      end
      S_IDLE: begin
        raddr = ROW_W'(in_row);
        waddr = ROW_W'(in_row);
        wbe   = MAX_COLUMNS'(1) << COL_W'(in_column);
        wdata = {MAX_COLUMNS{in_value}};
        we_cur = in_accept && (in_action == ACT_WRITE) && in_range;
      end
      S_ADV_START: raddr = '0;
      S_READ:      raddr = ROW_W'(r_inc);
      S_WRITE:     we_dst = 1'b1;
      S_COPY_WR: begin
        wdata  = rd_data;
        we_dst = 1'b1;
      end
      default: begin
      end
    endcase
    we_a = we_clr || (we_cur && !active_r) || (we_dst && active_r);
    we_b = we_clr || (we_cur && active_r) || (we_dst && !active_r);
  end

  lca_row_ram #(.DEPTH(MAX_ROWS), .WIDTH(MAX_COLUMNS)) u_plane_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wbe   (wbe),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  lca_row_ram #(.DEPTH(MAX_ROWS), .WIDTH(MAX_COLUMNS)) u_plane_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wbe   (wbe),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      r_r            <= '0;
      active_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      row_count_r    <= CFG_COUNT_RESET;
      column_count_r <= CFG_COUNT_RESET;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_COUNT:    row_count_r    <= cfg_data;
          REG_COLUMN_COUNT: column_count_r <= cfg_data;
          default: begin
          end
        endcase
      end

      // drop the result once taken; a new load below wins
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLEAR: begin
          if (32'(r_r) == 32'(MAX_ROWS - 1)) begin
            r_r <= '0;
          end else begin
            r_r <= r_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            unique case (in_action)
              ACT_WRITE: begin
                out_valid_r      <= 1'b1;
                out_cell_state_r <= 1'b0;
                out_accepted_r   <= in_range;
              end
              ACT_READ: begin
                col_hold_r <= COL_W'(in_column);
                if (!in_range) begin
                  out_valid_r      <= 1'b1;
                  out_cell_state_r <= 1'b0;
                  out_accepted_r   <= 1'b0;
                end
              end
              ACT_ADVANCE: r_r <= '0;
              default: begin
                out_valid_r      <= 1'b1;
                out_cell_state_r <= 1'b0;
                out_accepted_r   <= 1'b0;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          out_valid_r      <= 1'b1;
          out_cell_state_r <= rd_data[col_hold_r];
          out_accepted_r   <= 1'b1;
        end
        S_PRIME: begin
          cur_raw_r  <= rd_data;
          prev_raw_r <= '0;
        end
        S_LOAD: begin
          nxt_raw_r <= rd_data;
          wa_r      <= prev_raw_r & col_mask;
          wm_r      <= cur_raw_r & col_mask;
          wb_r      <= below_valid ? (rd_data & col_mask) : '0;
          mk_r      <= col_mask;
          dst_r     <= cur_raw_r;
          a_prev_r  <= 1'b0;
          m_prev_r  <= 1'b0;
          b_prev_r  <= 1'b0;
          col_r     <= '0;
        end
        S_SWEEP: begin
          a_prev_r <= wa_r[0];
          m_prev_r <= wm_r[0];
          b_prev_r <= wb_r[0];
          wa_r     <= wa_r >> 1;
          wm_r     <= wm_r >> 1;
          wb_r     <= wb_r >> 1;
          mk_r     <= mk_r >> 1;
          dst_r    <= {ins_bit, dst_r[MAX_COLUMNS-1:1]};
          col_r    <= col_r + 1'b1;
        end
        S_WRITE: begin
          r_r        <= ROW_W'(r_inc);
          prev_raw_r <= cur_raw_r;
          cur_raw_r  <= nxt_raw_r;
        end
        S_COPY_WR: begin
          r_r <= ROW_W'(r_inc);
        end
        S_DONE: begin
          active_r         <= ~active_r;
          out_valid_r      <= 1'b1;
          out_cell_state_r <= 1'b0;
          out_accepted_r   <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
